[src/stt_pkg.sv]
package stt_pkg;

    localparam int LINE_BITS   = 16;
    localparam int COLUMN_BITS = 12;
    localparam int MAX_RESULTS = 4;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_SQUOTE,
        MODE_DQUOTE,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_ERROR,
        MODE_DONE
    } mode_t;

    localparam logic [1:0] EV_CHAR  = 2'd0;
    localparam logic [1:0] EV_END   = 2'd1;
    localparam logic [1:0] EV_ERROR = 2'd2;
    localparam logic [1:0] EV_EOF   = 2'd3;

    localparam logic [4:0] CLS_IDENT = 5'd0;
    localparam logic [4:0] CLS_SLASH = 5'd19;

    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    typedef struct packed {
        logic [1:0] ev;
        logic [4:0] cls;
        logic [7:0] ch;
    } result_t;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
            || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic [4:0] sym_class(input logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            8'h28:   k = 5'd1;
            8'h29:   k = 5'd2;
            8'h7B:   k = 5'd3;
            8'h7D:   k = 5'd4;
            8'h5B:   k = 5'd5;
            8'h5D:   k = 5'd6;
            8'h2C:   k = 5'd7;
            8'h2E:   k = 5'd8;
            8'h3A:   k = 5'd9;
            8'h3B:   k = 5'd10;
            8'h3D:   k = 5'd11;
            8'h3F:   k = 5'd12;
            8'h3C:   k = 5'd13;
            8'h3E:   k = 5'd14;
            8'h5F:   k = 5'd15;
            8'h2A:   k = 5'd16;
            8'h2D:   k = 5'd17;
            8'h2B:   k = 5'd18;
            8'h2F:   k = CLS_SLASH;
            8'h25:   k = 5'd20;
            default: k = CLS_IDENT;
        endcase
        return k;
    endfunction

endpackage

[src/source_text_tokenizer.sv]
// Latency: results of a character appear the cycle after its transfer.
// Throughput: one character per cycle while each gives at most one result;
// while out_ready is high; a character with more results holds the buffer
// until its last result is taken. No-result characters go at one per cycle.
// Reset (rst_n, asynchronous): idle mode, line and column zero, buffer empty.
module source_text_tokenizer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        char_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        event_res,
    output logic [4:0]                        token_class,
    output logic [7:0]                        char_value_out,
    output logic [stt_pkg::LINE_BITS-1:0]     line_number,
    output logic [stt_pkg::COLUMN_BITS-1:0]   column_number,
    output logic                              last
);
    import stt_pkg::*;

    mode_t                  mode_reg;
    logic [LINE_BITS-1:0]   line_reg;
    logic [COLUMN_BITS-1:0] col_reg;

    result_t                buf_reg [MAX_RESULTS];
    result_t                buf_next [MAX_RESULTS];
    logic [LINE_BITS-1:0]   buf_line_reg;
    logic [COLUMN_BITS-1:0] buf_col_reg;
    logic [2:0]             cnt_reg;
    logic [2:0]             cnt_next;
    logic [1:0]             idx_reg;

    result_t                idle_r [2];
    logic [1:0]             idle_n;
    mode_t                  idle_mode;
    result_t                pre_r [2];
    logic [1:0]             pre_n;
    logic                   run_idle;
    mode_t                  mode_alt;
    mode_t                  mode_next;
    logic [4:0]             cls;
    logic                   take;
    logic                   pop;
    logic                   pop_last;

    assign out_valid = (cnt_reg != 3'd0);
    assign last      = ({1'b0, idx_reg} == cnt_reg - 3'd1);
    assign pop       = out_valid && out_ready;
    assign pop_last  = pop && last;
    assign in_ready  = !out_valid || pop_last;
    assign take      = in_valid && in_ready;

    assign event_res      = buf_reg[idx_reg].ev;
    assign token_class    = buf_reg[idx_reg].cls;
    assign char_value_out = buf_reg[idx_reg].ch;
    assign line_number    = buf_line_reg;
    assign column_number  = buf_col_reg;

    assign cls = sym_class(char_value);

    // byte handling with no token open
    always_comb
    begin
        idle_mode = MODE_IDLE;
        idle_n    = 2'd0;
        idle_r[0] = '0;
        idle_r[1] = '0;
        priority if (char_value == CH_SPACE || char_value == CH_TAB || char_value == CH_NL)
        begin
            idle_mode = MODE_IDLE;
        end
        else if (char_value == CH_SLASH)
        begin
            idle_mode = MODE_SLASH;
        end
        else if (char_value == CH_SQUOTE)
        begin
            idle_mode = MODE_SQUOTE;
        end
        else if (char_value == CH_DQUOTE)
        begin
            idle_mode = MODE_DQUOTE;
        end
        else if (is_alnum(char_value))
        begin
            idle_mode = MODE_IDENT;
            idle_n    = 2'd1;
            idle_r[0] = '{EV_CHAR, CLS_IDENT, char_value};
        end
        else if (cls != CLS_IDENT)
        begin
            idle_n    = 2'd2;
            idle_r[0] = '{EV_CHAR, cls, char_value};
            idle_r[1] = '{EV_END, cls, CH_NUL};
        end
        else if (char_value == CH_NUL)
        begin
            idle_mode = MODE_DONE;
            idle_n    = 2'd1;
            idle_r[0] = '{EV_EOF, CLS_IDENT, CH_NUL};
        end
        else
        begin
            idle_mode = MODE_ERROR;
            idle_n    = 2'd1;
            idle_r[0] = '{EV_ERROR, CLS_IDENT, char_value};
        end
    end

    // results that come before the idle handling, per mode
    always_comb
    begin
        pre_n     = 2'd0;
        pre_r[0]  = '0;
        pre_r[1]  = '0;
        run_idle  = 1'b0;
        mode_alt  = mode_reg;
        unique case (mode_reg)
            MODE_IDLE:
            begin
                run_idle = 1'b1;
            end
            MODE_IDENT:
            begin
                if (is_alnum(char_value))
                begin
                    pre_n    = 2'd1;
                    pre_r[0] = '{EV_CHAR, CLS_IDENT, char_value};
                end
                else
                begin
                    pre_n    = 2'd1;
                    pre_r[0] = '{EV_END, CLS_IDENT, CH_NUL};
                    run_idle = 1'b1;
                end
            end
            MODE_SQUOTE, MODE_DQUOTE:
            begin
                pre_n = 2'd1;
                if (char_value == ((mode_reg == MODE_SQUOTE) ? CH_SQUOTE : CH_DQUOTE))
                begin
                    pre_r[0] = '{EV_END, CLS_IDENT, CH_NUL};
                    mode_alt = MODE_IDLE;
                end
                else if (char_value == CH_NUL)
                begin
                    pre_r[0] = '{EV_ERROR, CLS_IDENT, CH_NUL};
                    mode_alt = MODE_ERROR;
                end
                else
                begin
                    pre_r[0] = '{EV_CHAR, CLS_IDENT, char_value};
                end
            end
            MODE_SLASH:
            begin
                if (char_value == CH_SLASH)
                begin
                    mode_alt = MODE_COMMENT;
                end
                else
                begin
                    pre_n    = 2'd2;
                    pre_r[0] = '{EV_CHAR, CLS_SLASH, CH_SLASH};
                    pre_r[1] = '{EV_END, CLS_SLASH, CH_NUL};
                    run_idle = 1'b1;
                end
            end
            MODE_COMMENT:
            begin
                if (char_value == CH_NL)
                begin
                    mode_alt = MODE_IDLE;
                end
                else if (char_value == CH_NUL)
                begin
                    pre_n    = 2'd1;
                    pre_r[0] = '{EV_EOF, CLS_IDENT, CH_NUL};
                    mode_alt = MODE_DONE;
                end
            end
            MODE_ERROR:
            begin
                pre_n    = 2'd1;
                pre_r[0] = '{EV_ERROR, CLS_IDENT, char_value};
            end
            MODE_DONE:
            begin
                pre_n    = 2'd1;
                pre_r[0] = '{EV_EOF, CLS_IDENT, CH_NUL};
            end
        endcase
    end

    // pack prefix and idle results into the buffer order
    always_comb
    begin
        logic [1:0] j;
        mode_next = run_idle ? idle_mode : mode_alt;
        cnt_next  = {1'b0, pre_n} + (run_idle ? {1'b0, idle_n} : 3'd0);
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            j = 2'(i) - pre_n;
            if (2'(i) < pre_n)
                buf_next[i] = pre_r[i[0]];
            else if (j < 2'd2)
                buf_next[i] = idle_r[j[0]];
            else
                buf_next[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            line_reg <= '0;
            col_reg  <= '0;
            cnt_reg  <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            if (take)
            begin
                mode_reg <= mode_next;
                cnt_reg  <= cnt_next;
                idx_reg  <= '0;
                if (mode_next != MODE_ERROR && mode_next != MODE_DONE)
                begin
                    if (char_value == CH_NL)
                    begin
                        if (line_reg != '1)
                            line_reg <= line_reg + LINE_BITS'(1);
                        col_reg <= '0;
                    end
                    else if (col_reg != '1)
                    begin
                        col_reg <= col_reg + COLUMN_BITS'(1);
                    end
                end
            end
            else if (pop_last)
            begin
                cnt_reg <= '0;
                idx_reg <= '0;
            end
            else if (pop)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            buf_reg      <= buf_next;
            buf_line_reg <= line_reg;
            buf_col_reg  <= col_reg;
        end
    end

endmodule

[src/stt_checker.sv]
module stt_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [1:0]                        event_res,
    input  logic [4:0]                        token_class,
    input  logic [7:0]                        char_value_out,
    input  logic [stt_pkg::LINE_BITS-1:0]     line_number,
    input  logic [stt_pkg::COLUMN_BITS-1:0]   column_number,
    input  logic                              last
);
    import stt_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res)
            && $stable(char_value_out) && $stable(line_number) && $stable(column_number))
    else $error("stalled result changed");

    // empty output side never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input blocked with no result pending");

    // results of one character follow without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
    else $error("gap inside one character's results");

    // error and end of input carry no class; end of input carries no byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_ERROR || event_res == EV_EOF) |->
            token_class == CLS_IDENT
            && (event_res == EV_ERROR || char_value_out == CH_NUL))
    else $error("bad fields on error or end of input");

    // input transfers occur only with no result pending or as the last result is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_valid |-> out_ready && last)
    else $error("character taken while results still pending");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_res      (event_res),
    .token_class    (token_class),
    .char_value_out (char_value_out),
    .line_number    (line_number),
    .column_number  (column_number),
    .last           (last)
);

[sim/token_stream_checker.sv]
module token_stream_checker
    import stt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [7:0]             char_value,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [1:0]             event_res,
    input  logic [4:0]             token_class,
    input  logic [7:0]             char_value_out,
    input  logic [LINE_BITS-1:0]   line_number,
    input  logic [COLUMN_BITS-1:0] column_number,
    input  logic                   last,
    output int                     fail_count,
    output int                     expected_left
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]             ev;
        logic [4:0]             cls;
        logic [7:0]             ch;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] col;
        logic                   fin;
    } token_result_t;

    // punctuation bytes, class is index + 1
    localparam logic [7:0] PUNCT [20] = '{
        8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h2C, 8'h2E, 8'h3A, 8'h3B,
        8'h3D, 8'h3F, 8'h3C, 8'h3E, 8'h5F, 8'h2A, 8'h2D, 8'h2B, 8'h2F, 8'h25
    };

    mode_t                  scan_mode;
    logic [LINE_BITS-1:0]   line_pos;
    logic [COLUMN_BITS-1:0] column_pos;
    token_result_t          expected_q [$];
    token_result_t          step_res [MAX_RESULTS];
    int                     step_n;
    token_result_t          want;
    int                     fails;

    initial
    begin
        fail_count    = 0;
        expected_left = 0;
    end

    function automatic logic word_char(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
            || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic [4:0] punct_class(input logic [7:0] c);
        int k;
        for (k = 0; k < 20; k++)
        begin
            if (PUNCT[k] == c)
                return 5'(k + 1);
        end
        return CLS_IDENT;
    endfunction

    function automatic void emit(input logic [1:0] ev, input logic [4:0] cls,
                                 input logic [7:0] ch);
        step_res[step_n] = '{ev, cls, ch, line_pos, column_pos, 1'b0};
        step_n++;
    endfunction

    // byte arriving with no token open
    function automatic void take_fresh(input logic [7:0] c);
        logic [4:0] k;
        k = punct_class(c);
        scan_mode = MODE_IDLE;
        if (c == CH_SPACE || c == CH_TAB || c == CH_NL)
            return;
        if (c == CH_SLASH)
            scan_mode = MODE_SLASH;
        else if (c == CH_SQUOTE)
            scan_mode = MODE_SQUOTE;
        else if (c == CH_DQUOTE)
            scan_mode = MODE_DQUOTE;
        else if (word_char(c))
        begin
            scan_mode = MODE_IDENT;
            emit(EV_CHAR, CLS_IDENT, c);
        end
        else if (k != CLS_IDENT)
        begin
            emit(EV_CHAR, k, c);
            emit(EV_END, k, CH_NUL);
        end
        else if (c == CH_NUL)
        begin
            scan_mode = MODE_DONE;
            emit(EV_EOF, CLS_IDENT, CH_NUL);
        end
        else
        begin
            scan_mode = MODE_ERROR;
            emit(EV_ERROR, CLS_IDENT, c);
        end
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        logic [7:0] quote;
        int i;
        step_n = 0;
        case (scan_mode)
            MODE_IDLE:
                take_fresh(c);
            MODE_IDENT:
            begin
                if (word_char(c))
                    emit(EV_CHAR, CLS_IDENT, c);
                else
                begin
                    emit(EV_END, CLS_IDENT, CH_NUL);
                    take_fresh(c);
                end
            end
            MODE_SQUOTE, MODE_DQUOTE:
            begin
                quote = (scan_mode == MODE_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;
                if (c == quote)
                begin
                    emit(EV_END, CLS_IDENT, CH_NUL);
                    scan_mode = MODE_IDLE;
                end
                else if (c == CH_NUL)
                begin
                    emit(EV_ERROR, CLS_IDENT, CH_NUL);
                    scan_mode = MODE_ERROR;
                end
                else
                    emit(EV_CHAR, CLS_IDENT, c);
            end
            MODE_COMMENT:
            begin
                if (c == CH_NL)
                    scan_mode = MODE_IDLE;
                else if (c == CH_NUL)
                begin
                    emit(EV_EOF, CLS_IDENT, CH_NUL);
                    scan_mode = MODE_DONE;
                end
            end
            MODE_SLASH:
            begin
                if (c == CH_SLASH)
                    scan_mode = MODE_COMMENT;
                else
                begin
                    emit(EV_CHAR, CLS_SLASH, CH_SLASH);
                    emit(EV_END, CLS_SLASH, CH_NUL);
                    take_fresh(c);
                end
            end
            MODE_ERROR:
                emit(EV_ERROR, CLS_IDENT, c);
            MODE_DONE:
                emit(EV_EOF, CLS_IDENT, CH_NUL);
            default:
                take_fresh(c);
        endcase

        // position frozen once in error or done
        if (scan_mode != MODE_ERROR && scan_mode != MODE_DONE)
        begin
            if (c == CH_NL)
            begin
                if (line_pos != '1)
                    line_pos++;
                column_pos = '0;
            end
            else if (column_pos != '1)
                column_pos++;
        end

        if (step_n > 0)
            step_res[step_n - 1].fin = 1'b1;
        for (i = 0; i < step_n; i++)
            expected_q.push_back(step_res[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode  = MODE_IDLE;
            line_pos   = '0;
            column_pos = '0;
            expected_q.delete();
            fails      = 0;
        end
        else
        begin
            // results first: a transfer's results never arrive in its own cycle
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    fails++;
                    $display("%0t ns: unexpected result ev %0d class %0d char %02h line %0d col %0d last %0b",
                             $time, event_res, token_class, char_value_out,
                             line_number, column_number, last);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (event_res !== want.ev || token_class !== want.cls
                        || char_value_out !== want.ch || line_number !== want.line
                        || column_number !== want.col || last !== want.fin)
                    begin
                        fails++;
                        $display("%0t ns: expected ev %0d class %0d char %02h line %0d col %0d last %0b",
                                 $time, want.ev, want.cls, want.ch, want.line,
                                 want.col, want.fin);
                        $display("%0t ns: actual   ev %0d class %0d char %02h line %0d col %0d last %0b",
                                 $time, event_res, token_class, char_value_out,
                                 line_number, column_number, last);
                    end
                end
            end
            if (in_valid && in_ready)
                scan_char(char_value);
        end
        fail_count    <= fails;
        expected_left <= expected_q.size();
    end

endmodule

[sim/source_text_tokenizer_test.sv]
module source_text_tokenizer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import stt_pkg::*;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   in_valid   = 1'b0;
    logic [7:0]             char_value = 8'd0;
    logic                   out_ready  = 1'b0;
    logic                   in_ready;
    logic                   out_valid;
    logic [1:0]             event_res;
    logic [4:0]             token_class;
    logic [7:0]             char_value_out;
    logic [LINE_BITS-1:0]   line_number;
    logic [COLUMN_BITS-1:0] column_number;
    logic                   last;
    int                     fail_count;
    int                     expected_left;

    int                     send_idle  = 0;
    int                     recv_stall = 0;
    logic [7:0]             source_q [$];
    string                  punct      = "(){}[],.:;=?<>_*-+/%";
    string                  bad_chars  = "!#$&@^`|~";

    source_text_tokenizer u_dut (.*);

    token_stream_checker u_check (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall);

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            source_q.push_back(s[i]);
    endtask

    task automatic push_white();
        case ($urandom_range(0, 2))
            0: source_q.push_back(CH_SPACE);
            1: source_q.push_back(CH_TAB);
            default: source_q.push_back(CH_NL);
        endcase
    endtask

    // mostly well-formed tokens with random content, some loose whitespace
    task automatic push_token();
        int sel;
        int len;
        int i;
        int r;
        logic [7:0] quote;
        logic [7:0] b;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2:
            begin
                len = $urandom_range(1, 6);
                for (i = 0; i < len; i++)
                begin
                    r = $urandom_range(0, 61);
                    if (r < 10)
                        source_q.push_back(8'(8'h30 + r));
                    else if (r < 36)
                        source_q.push_back(8'(8'h41 + r - 10));
                    else
                        source_q.push_back(8'(8'h61 + r - 36));
                end
            end
            3, 4:
                source_q.push_back(punct[$urandom_range(0, 19)]);
            5, 6:
            begin
                quote = (sel == 5) ? CH_SQUOTE : CH_DQUOTE;
                source_q.push_back(quote);
                len = $urandom_range(0, 5);
                for (i = 0; i < len; i++)
                begin
                    b = quote;
                    while (b == quote)
                        b = 8'($urandom_range(1, 255));
                    source_q.push_back(b);
                end
                source_q.push_back(quote);
            end
            7:
            begin
                push_text("//");
                len = $urandom_range(0, 8);
                for (i = 0; i < len; i++)
                begin
                    b = CH_NL;
                    while (b == CH_NL)
                        b = 8'($urandom_range(1, 255));
                    source_q.push_back(b);
                end
                source_q.push_back(CH_NL);
            end
            default:
            begin
                len = $urandom_range(1, 3);
                for (i = 0; i < len; i++)
                    push_white();
            end
        endcase
        if ($urandom_range(0, 1) == 0)
            push_white();
    endtask

    task automatic push_random(input int n);
        int start;
        start = source_q.size();
        while (source_q.size() - start < n)
            push_token();
    endtask

    // error or end of input; sticky, so one per run
    task automatic push_ending();
        int i;
        case ($urandom_range(0, 3))
            0:
            begin
                case ($urandom_range(0, 2))
                    0: source_q.push_back(8'($urandom_range(128, 255)));
                    1: source_q.push_back(8'($urandom_range(1, 8)));
                    default: source_q.push_back(bad_chars[$urandom_range(0, 8)]);
                endcase
            end
            1:
            begin
                push_text(" \"ab");
                source_q.push_back(CH_NUL);
            end
            2:
            begin
                push_text(" //zz");
                source_q.push_back(CH_NUL);
            end
            default:
            begin
                push_text(" ");
                source_q.push_back(CH_NUL);
            end
        endcase
        source_q.push_back(8'hFF);
        source_q.push_back(CH_NUL);
        for (i = 0; i < 12; i++)
            source_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        char_value <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_all();
        while (source_q.size() != 0)
            send_char(source_q.pop_front());
        in_valid <= 1'b0;
    endtask

    // hold the sender until every expected result has been seen
    task automatic drain();
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int s_idle, input int r_stall, input int n);
        send_idle  = s_idle;
        recv_stall = r_stall;
        push_random(n);
        send_all();
        drain();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identifier extremes, token ends, held slash, comment, both quote kinds
        push_text("AZaz09)/a\t//q\n'\"");
        source_q.push_back(8'hFF);
        push_text("'\"'\"% /(");
        run_phase(0, 0, 52);
        run_phase(63, 0, 52);
        run_phase(0, 63, 52);
        run_phase(23, 23, 52);

        send_idle  = 23;
        recv_stall = 23;
        push_ending();
        send_all();
        drain();
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
